### design/splmx_pkg.sv
`default_nettype none

package splmx_pkg;

  // Word and beat widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned CNT_W   = $clog2(WORD_W);
  localparam int unsigned OP_W    = 2;
  localparam int unsigned REQ_W   = 4;
  localparam int unsigned USED_W  = 3;
  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 72;
  localparam int unsigned CFG_A_W = 1;

  // splmx constants
  localparam logic [WORD_W-1:0] GOLDEN  = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] GOLDEN2 = GOLDEN << 1;
  localparam logic [WORD_W-1:0] MIX_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_B   = 64'h94D049BB133111EB;
  localparam int unsigned       SHR_1   = 30;
  localparam int unsigned       SHR_2   = 27;
  localparam int unsigned       SHR_3   = 31;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_ROOT_SEED = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_FALLBACK  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_RESEED = 2'd0,
    OP_DRAW   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Mixer sequencer: three partial products per 64-bit multiply, two rounds
  typedef enum logic [2:0] {
    MX_IDLE,
    MX_LL,
    MX_LH,
    MX_HL,
    MX_FIN
  } mx_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MIX,
    ST_MOD,
    ST_SEED,
    ST_SEEDW,
    ST_DONE
  } ctl_state_e;

endpackage

`default_nettype wire

### design/splmx_store.sv
`default_nettype none

module splmx_store import splmx_pkg::*; #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned AW          = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0]      mem [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] vld_q;
  logic [WORD_W-1:0]      rdata_q;
  logic                   rvld_q;

  // State memory, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Per-entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

### design/splmx_mix.sv
`default_nettype none

module splmx_mix import splmx_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] x_i,
  output logic                   done_o,
  output logic      [WORD_W-1:0] res_o
);

  mx_state_e         state_q, state_d;
  logic              rnd_q;
  logic              done_q;
  logic [WORD_W-1:0] z_q, acc_q, prod_q, res_q;
  logic [WORD_W-1:0] mul_c, sum;
  logic [HALF_W-1:0] op_a, op_b;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MX_IDLE: if (start_i) state_d = MX_LL;
      MX_LL:   state_d = MX_LH;
      MX_LH:   state_d = MX_HL;
      MX_HL:   state_d = MX_FIN;
      MX_FIN:  state_d = rnd_q ? MX_IDLE : MX_LL;
      default: state_d = MX_IDLE;
    endcase
  end

  // Multiplier operand selection, partial products of the low 64 bits
  always_comb begin
    mul_c = rnd_q ? MIX_B : MIX_A;
    op_a  = z_q[HALF_W-1:0];
    op_b  = mul_c[HALF_W-1:0];
    unique case (state_q)
      MX_LH:   op_b = mul_c[WORD_W-1:HALF_W];
      MX_HL:   op_a = z_q[WORD_W-1:HALF_W];
      default: ;
    endcase
  end

  assign sum = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MX_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MX_FIN) && rnd_q;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    unique case (state_q)
      MX_IDLE: begin
        if (start_i) begin
          z_q   <= x_i ^ (x_i >> SHR_1);
          acc_q <= '0;
          rnd_q <= 1'b0;
        end
      end
      MX_LH: acc_q <= acc_q + prod_q;
      MX_HL: acc_q <= sum;
      MX_FIN: begin
        if (!rnd_q) begin
          z_q   <= sum ^ (sum >> SHR_2);
          acc_q <= '0;
          rnd_q <= 1'b1;
        end else begin
          res_q <= sum ^ (sum >> SHR_3);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

### design/splmx_mod.sv
`default_nettype none

module splmx_mod import splmx_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [WORD_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [WORD_W-1:0] rem_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] dvd_q, dsr_q, rem_q;
  logic [WORD_W:0]   rem_sh, rem_sub;

  // One restoring step per cycle, dividend bits taken MSB first
  assign rem_sh  = {rem_q, dvd_q[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Pulse once the last step has gone in
      done_q <= busy_q && (cnt_q == CNT_W'(WORD_W - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0] : rem_sub[WORD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### design/multi_stream_splitmix_rng.sv
// Channel      | Dir | Handshake                    | Beat contents (LSB first)
// s_axis       | in  | s_axis_tvalid / s_axis_tready | op[1:0], stream[5:2], bound[69:6]
// m_axis       | out | m_axis_tvalid / m_axis_tready | value[63:0], stream_used[66:64]
// cfg          | in  | cfg_we_i (no wait)           | idx 0 root_seed, idx 1 fallback_stream
//
// Per beat: a draw reads and updates the stream state and runs the mixer, a
// bounded draw also runs the bit-serial remainder unit, and a reseed makes one
// pass of the shared mixer and one state write per stream. The mixer builds each 64-bit
// product from three 32x32 partial products. Reset clears all stream states
// at once through per-entry valid bits. A result waiting on m_axis does not
// block the next input beat; only the hand-over of the following result waits.
`default_nettype none

module multi_stream_splitmix_rng import splmx_pkg::*; #(
  parameter int unsigned NUM_STREAMS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input stream: op, stream, bound
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [IN_W-1:0]    s_axis_tdata,
  // Output stream: value, stream_used
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [OUT_W-1:0]   m_axis_tdata,
  // Configuration writes
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_A_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]  cfg_data_i
);

  localparam int unsigned AW  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int unsigned MAP_W = 7;

  ctl_state_e        state_q, state_d;

  logic [WORD_W-1:0] root_q;
  logic [USED_W-1:0] fallback_q;

  op_e               in_op, op_q;
  logic [REQ_W-1:0]  in_req;
  logic [WORD_W-1:0] in_bound, bound_q;
  logic [MAP_W-1:0]  map_k;
  logic [AW-1:0]     k_q, idx_q;
  logic [USED_W-1:0] used_q;
  logic [WORD_W-1:0] t_q, res_q, seed;
  logic              accept;

  logic              out_vld_q;
  logic [OUT_W-1:0]  out_data_q;
  logic              out_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata, st_new;

  logic              mix_start, mix_done;
  logic [WORD_W-1:0] mix_in, mix_res;
  logic              mod_start, mod_done;
  logic [WORD_W-1:0] mod_rem;

  // Beat unpacking
  assign in_op    = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_req   = s_axis_tdata[OP_W +: REQ_W];
  assign in_bound = s_axis_tdata[OP_W+REQ_W +: WORD_W];
  assign accept   = s_axis_tvalid && s_axis_tready;

  // Stream mapping with fallback, then stream 0
  always_comb begin
    if ({3'b000, in_req} < MAP_W'(NUM_STREAMS)) begin
      map_k = {3'b000, in_req};
    end else if ({4'b0000, fallback_q} < MAP_W'(NUM_STREAMS)) begin
      map_k = {4'b0000, fallback_q};
    end else begin
      map_k = '0;
    end
  end

  assign seed   = (root_q != '0) ? root_q : GOLDEN;
  assign st_new = mem_rdata + GOLDEN;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q     <= '0;
      fallback_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROOT_SEED: root_q     <= cfg_data_i;
        CFG_FALLBACK:  fallback_q <= cfg_data_i[USED_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_RESEED: state_d = ST_SEED;
            OP_DRAW:   state_d = ST_RD;
            OP_RANGE:  state_d = (in_bound == '0) ? ST_DONE : ST_RD;
            OP_NONE:   state_d = ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_RD:  state_d = ST_MIX;
      ST_MIX: begin
        if (mix_done) state_d = (op_q == OP_RANGE) ? ST_MOD : ST_DONE;
      end
      ST_MOD:  if (mod_done) state_d = ST_DONE;
      ST_SEED: state_d = ST_SEEDW;
      ST_SEEDW: begin
        if (mix_done) begin
          state_d = (idx_q == AW'(NUM_STREAMS - 1)) ? ST_DONE : ST_SEED;
        end
      end
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = k_q;
    mem_wdata     = st_new;
    mix_start     = 1'b0;
    mix_in        = st_new;
    mod_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RD: begin
        mem_we    = 1'b1;
        mix_start = 1'b1;
      end
      ST_MIX:  mod_start = mix_done && (op_q == OP_RANGE);
      ST_SEED: begin
        mix_start = 1'b1;
        mix_in    = t_q;
      end
      ST_SEEDW: begin
        mem_we    = mix_done;
        mem_waddr = idx_q;
        mem_wdata = mix_res;
      end
      ST_DONE: out_load = !out_vld_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      bound_q <= in_bound;
      k_q     <= map_k[AW-1:0];
      res_q   <= '0;
      t_q     <= seed + GOLDEN2;
      idx_q   <= '0;
      unique case (in_op)
        OP_DRAW, OP_RANGE: used_q <= map_k[USED_W-1:0];
        default:           used_q <= '0;
      endcase
    end
    if (state_q == ST_MIX && mix_done) begin
      res_q <= mix_res;
    end
    if (state_q == ST_MOD && mod_done) begin
      res_q <= mod_rem;
    end
    if (state_q == ST_SEEDW && mix_done) begin
      t_q   <= t_q + GOLDEN;
      idx_q <= idx_q + 1'b1;
      res_q <= '0;
    end
    if (out_load) begin
      out_data_q <= {(OUT_W - WORD_W - USED_W)'(0), used_q, res_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  splmx_store #(
    .NUM_STREAMS (NUM_STREAMS),
    .AW          (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (map_k[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  splmx_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .x_i     (mix_in),
    .done_o  (mix_done),
    .res_o   (mix_res)
  );

  splmx_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mix_res),
    .divisor_i  (bound_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

endmodule

`default_nettype wire
